/* rtl/idiv_pkg.sv */
// Shared constants and the stage payload type for the pipelined integer divider.
`timescale 1ns / 1ps
`default_nettype none

package idiv_pkg;

    // Operand width used by the datapath; the port fields stay FIELD_W wide.
    localparam int DATA_WIDTH = 64;
    localparam int FIELD_W    = 64;
    localparam int TDATA_W    = 2 * FIELD_W;

    // Mode selector codes carried in tuser
    localparam logic FUNC_SIGNED   = 1'b0;
    localparam logic FUNC_UNSIGNED = 1'b1;

    // Payload carried down the division pipe
    typedef struct packed {
        logic                  neg_q;   // negate quotient at the end
        logic                  neg_r;   // negate remainder at the end
        logic                  dbz;     // divisor was zero
        logic [DATA_WIDTH-1:0] rem;     // partial remainder
        logic [DATA_WIDTH-1:0] nq;      // dividend bits out, quotient bits in
        logic [DATA_WIDTH-1:0] den;     // divisor magnitude
    } step_t;

endpackage

`default_nettype wire

/* rtl/idiv_pre.sv */
// Input stage: operand masking, magnitude conversion and sign bookkeeping.
`timescale 1ns / 1ps
`default_nettype none

module idiv_pre (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic                          in_func,
    input  wire logic [idiv_pkg::FIELD_W-1:0]  in_dividend,
    input  wire logic [idiv_pkg::FIELD_W-1:0]  in_divisor,
    output logic                               out_valid,
    output idiv_pkg::step_t                    out_data
);

    logic                            valid_reg;
    logic                            valid_next;
    idiv_pkg::step_t                 data_reg;
    idiv_pkg::step_t                 data_next;
    logic [idiv_pkg::DATA_WIDTH-1:0] a;
    logic [idiv_pkg::DATA_WIDTH-1:0] b;
    logic                            a_neg;
    logic                            b_neg;

    always_comb begin
        a     = in_dividend[idiv_pkg::DATA_WIDTH-1:0];
        b     = in_divisor[idiv_pkg::DATA_WIDTH-1:0];
        a_neg = (in_func == idiv_pkg::FUNC_SIGNED) && a[idiv_pkg::DATA_WIDTH-1];
        b_neg = (in_func == idiv_pkg::FUNC_SIGNED) && b[idiv_pkg::DATA_WIDTH-1];

        data_next.neg_q = a_neg ^ b_neg;
        data_next.neg_r = a_neg;
        data_next.dbz   = (b == '0);
        data_next.rem   = '0;
        data_next.nq    = a_neg ? (~a + 1'b1) : a;
        data_next.den   = b_neg ? (~b + 1'b1) : b;

        valid_next = en ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* rtl/idiv_step.sv */
// One registered restoring-division step: shift in a dividend bit, trial subtract.
`timescale 1ns / 1ps
`default_nettype none

module idiv_step (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire idiv_pkg::step_t in_data,
    output logic                 out_valid,
    output idiv_pkg::step_t      out_data
);

    localparam int W = idiv_pkg::DATA_WIDTH;

    logic            valid_reg;
    logic            valid_next;
    idiv_pkg::step_t data_reg;
    idiv_pkg::step_t data_next;
    logic [W-1:0]    shifted;
    logic [W:0]      diff;
    logic            take;

    always_comb begin
        // carry out of the shift counts as part of the trial value
        shifted = {in_data.rem[W-2:0], in_data.nq[W-1]};
        diff    = {in_data.rem[W-1], shifted} - {1'b0, in_data.den};
        take    = ~diff[W];

        data_next     = in_data;
        data_next.rem = take ? diff[W-1:0] : shifted;
        data_next.nq  = {in_data.nq[W-2:0], take};

        valid_next = en ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* rtl/idiv_post.sv */
// Output stage: sign fix-up, zero-divisor forcing and the result register.
`timescale 1ns / 1ps
`default_nettype none

module idiv_post (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire idiv_pkg::step_t               in_data,
    output logic                               out_valid,
    output logic [idiv_pkg::FIELD_W-1:0]       out_quotient,
    output logic [idiv_pkg::FIELD_W-1:0]       out_remainder,
    output logic                               out_dbz
);

    localparam int W = idiv_pkg::DATA_WIDTH;
    localparam int F = idiv_pkg::FIELD_W;

    logic         valid_reg;
    logic         valid_next;
    logic [F-1:0] quot_reg;
    logic [F-1:0] quot_next;
    logic [F-1:0] rem_reg;
    logic [F-1:0] rem_next;
    logic         dbz_reg;
    logic [W-1:0] q_fix;
    logic [W-1:0] r_fix;

    always_comb begin
        q_fix = in_data.neg_q ? (~in_data.nq + 1'b1) : in_data.nq;
        r_fix = in_data.neg_r ? (~in_data.rem + 1'b1) : in_data.rem;
        if (in_data.dbz) begin
            quot_next = '0;
            rem_next  = '0;
        end else begin
            quot_next = F'(q_fix);
            rem_next  = F'(r_fix);
        end
        valid_next = en ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            dbz_reg  <= in_data.dbz;
        end
    end

    assign out_valid     = valid_reg;
    assign out_quotient  = quot_reg;
    assign out_remainder = rem_reg;
    assign out_dbz       = dbz_reg;

endmodule

`default_nettype wire

/* rtl/int64_divider_signed_unsigned.sv */
// Top level of the pipelined signed/unsigned 64-bit integer divider.
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider. Each slave transfer carries a dividend and a
// divisor in s_tdata and the mode in s_tuser (0 signed, 1 unsigned); each one
// gives exactly one master transfer with quotient and remainder in m_tdata and
// a divide-by-zero flag in m_tuser. Signed quotients truncate toward zero and
// the remainder follows the dividend's sign; the most negative value over
// minus one wraps to the most negative value with remainder 0; a zero divisor
// gives quotient 0, remainder 0 and the flag set. A new transfer can be taken
// every cycle unless the output is held. Stages: one input stage forming
// magnitudes, one stage per quotient bit (a single trial subtract each) and
// one output stage for sign fix-up. All stages advance together while the
// output register is empty or being read; a one-entry input skid keeps
// s_tready a plain register. No clearing pass after reset.
module int64_divider_signed_unsigned (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [idiv_pkg::TDATA_W-1:0]  s_tdata,   // [63:0] dividend, [127:64] divisor
    input  wire logic                          s_tuser,   // [0] func
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [idiv_pkg::TDATA_W-1:0]       m_tdata,   // [63:0] quotient, [127:64] remainder
    output logic                               m_tuser    // [0] div_by_zero
);

    localparam int F      = idiv_pkg::FIELD_W;
    localparam int NSTAGE = idiv_pkg::DATA_WIDTH;

    // pipe enable: everything moves unless the output is held
    logic en;

    // input skid register
    logic                           skid_valid_reg;
    logic                           skid_valid_next;
    logic [idiv_pkg::TDATA_W-1:0]   skid_data_reg;
    logic                           skid_func_reg;
    logic                           s_tready_reg;
    logic                           s_tready_next;
    logic                           s_xfer;

    // pipe entry
    logic                           in_valid;
    logic [idiv_pkg::TDATA_W-1:0]   in_data;
    logic                           in_func;

    // step chain
    logic            stg_valid [NSTAGE+1];
    idiv_pkg::step_t stg_data  [NSTAGE+1];

    logic [F-1:0] quotient;
    logic [F-1:0] remainder;

    assign en     = ~m_tvalid | m_tready;
    assign s_xfer = s_tvalid & s_tready_reg;

    // Skid: when the pipe is frozen, a transfer taken this cycle parks here.
    always_comb begin
        if (en) begin
            skid_valid_next = 1'b0;
        end else begin
            skid_valid_next = skid_valid_reg | s_xfer;
        end
        s_tready_next = ~skid_valid_next;

        in_valid = skid_valid_reg | s_xfer;
        in_data  = skid_valid_reg ? skid_data_reg : s_tdata;
        in_func  = skid_valid_reg ? skid_func_reg : s_tuser;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            s_tready_reg   <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            s_tready_reg   <= s_tready_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg && !en) begin
            skid_data_reg <= s_tdata;
            skid_func_reg <= s_tuser;
        end
    end

    assign s_tready = s_tready_reg;

    idiv_pre u_pre (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (in_valid),
        .in_func     (in_func),
        .in_dividend (in_data[F-1:0]),
        .in_divisor  (in_data[2*F-1:F]),
        .out_valid   (stg_valid[0]),
        .out_data    (stg_data[0])
    );

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < NSTAGE; i++) begin : g_step
        idiv_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stg_valid[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    idiv_post u_post (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (stg_valid[NSTAGE]),
        .in_data       (stg_data[NSTAGE]),
        .out_valid     (m_tvalid),
        .out_quotient  (quotient),
        .out_remainder (remainder),
        .out_dbz       (m_tuser)
    );

    assign m_tdata = {remainder, quotient};

    // The slave side is closed whenever the skid holds an item
    a_skid_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !s_tready)
        else $error("skid occupied while s_tready high");

    // A transfer taken while the pipe is frozen must be parked
    a_skid_park : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !en) |=> skid_valid_reg)
        else $error("transfer during stall not held in skid");

    // Final partial remainder is below the divisor magnitude
    a_rem_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (stg_valid[NSTAGE] && !stg_data[NSTAGE].dbz) |->
            (stg_data[NSTAGE].rem < stg_data[NSTAGE].den))
        else $error("remainder not reduced below divisor");

    // Zero divisor yields zero quotient and remainder
    a_dbz_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("divide by zero result not cleared");

endmodule

`default_nettype wire

/* tb/sv/tb_int64_divider_signed_unsigned.sv */
// Self-checking testbench for the pipelined signed/unsigned 64-bit integer divider.
`timescale 1ns / 1ps

module tb_int64_divider_signed_unsigned;

    localparam int   DW            = idiv_pkg::DATA_WIDTH;
    localparam int   FIELD_W       = idiv_pkg::FIELD_W;
    localparam int   TDATA_W       = idiv_pkg::TDATA_W;
    localparam logic FUNC_SIGNED   = idiv_pkg::FUNC_SIGNED;
    localparam logic FUNC_UNSIGNED = idiv_pkg::FUNC_UNSIGNED;
    localparam int   RAND_ITEMS  = 1600;
    localparam int   QUIET_ITEMS = 200;       // tail of the run with no idling at all
    localparam int   CYCLE_LIMIT = 400000;    // watchdog bound on the whole run
    localparam int   DRAIN_WAIT  = DW + 16;   // pipe latency plus margin

    localparam logic [FIELD_W-1:0] SMIN = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic [FIELD_W-1:0] SMAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic [FIELD_W-1:0] ONES = {FIELD_W{1'b1}};
    localparam logic [FIELD_W-1:0] ZERO = {FIELD_W{1'b0}};

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
        logic               div_by_zero;
    } div_result_t;

    // One directed stimulus row; 'typed' rows carry a hand-written expectation.
    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
        logic               typed;
        div_result_t        res;
    } div_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;

    div_result_t pending_divs[$];
    int          errors     = 0;
    int          cycles     = 0;
    bit          quiet_tail = 1'b0;
    bit          src_gaps   = 1'b1;

    div_row_t directed_rows [0:21] = '{
        // zero divisor in both modes
        '{FUNC_UNSIGNED, ZERO, ZERO, 1'b1, '{ZERO, ZERO, 1'b1}},
        '{FUNC_SIGNED, 64'd5, ZERO, 1'b1, '{ZERO, ZERO, 1'b1}},
        '{FUNC_UNSIGNED, ONES, ZERO, 1'b1, '{ZERO, ZERO, 1'b1}},
        // most negative over minus one wraps; other extreme operands
        '{FUNC_SIGNED, SMIN, ONES, 1'b1, '{SMIN, ZERO, 1'b0}},
        '{FUNC_SIGNED, SMIN, 64'd1, 1'b1, '{SMIN, ZERO, 1'b0}},
        '{FUNC_SIGNED, SMIN, SMIN, 1'b1, '{64'd1, ZERO, 1'b0}},
        '{FUNC_SIGNED, SMAX, SMIN, 1'b1, '{ZERO, SMAX, 1'b0}},
        '{FUNC_UNSIGNED, ONES, 64'd1, 1'b1, '{ONES, ZERO, 1'b0}},
        '{FUNC_UNSIGNED, ONES, ONES, 1'b1, '{64'd1, ZERO, 1'b0}},
        '{FUNC_UNSIGNED, ZERO, ONES, 1'b1, '{ZERO, ZERO, 1'b0}},
        '{FUNC_SIGNED, ONES, ONES, 1'b1, '{64'd1, ZERO, 1'b0}},
        '{FUNC_SIGNED, ZERO, ONES, 1'b1, '{ZERO, ZERO, 1'b0}},
        // truncation toward zero, remainder follows the dividend
        '{FUNC_UNSIGNED, 64'd7, 64'd2, 1'b1, '{64'd3, 64'd1, 1'b0}},
        '{FUNC_SIGNED, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFD, ONES, 1'b0}},
        '{FUNC_SIGNED, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
          '{64'hFFFF_FFFF_FFFF_FFFD, 64'd1, 1'b0}},
        '{FUNC_SIGNED, 64'hFFFF_FFFF_FFFF_FFF9, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
          '{64'd3, ONES, 1'b0}},
        // the rest go through the predictor
        '{FUNC_SIGNED, SMIN, 64'd2, 1'b0, '0},
        '{FUNC_SIGNED, SMIN, SMAX, 1'b0, '0},
        '{FUNC_SIGNED, ONES, SMAX, 1'b0, '0},
        '{FUNC_UNSIGNED, SMIN, ONES, 1'b0, '0},
        '{FUNC_UNSIGNED, ONES, SMIN, 1'b0, '0},
        '{FUNC_UNSIGNED, 64'd1234567890123, 64'd97, 1'b0, '0}
    };

    int64_divider_signed_unsigned DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Restoring division of DW-bit magnitudes, one quotient bit per step.
    function automatic void restore_divide(input logic [DW-1:0] n, input logic [DW-1:0] d,
                                           output logic [DW-1:0] q, output logic [DW-1:0] r);
        logic carry;
        q = '0;
        r = '0;
        for (int i = DW - 1; i >= 0; i--) begin
            carry = r[DW-1];
            r = {r[DW-2:0], n[i]};
            if (carry || r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
    endfunction

    function automatic div_result_t predict_division(input logic func,
                                                     input logic [FIELD_W-1:0] dividend,
                                                     input logic [FIELD_W-1:0] divisor);
        div_result_t   res;
        logic [DW-1:0] a, b, ua, ub, q, r;
        logic          a_neg, b_neg;
        a   = dividend[DW-1:0];
        b   = divisor[DW-1:0];
        res = '0;
        if (b == '0) begin
            res.div_by_zero = 1'b1;
            return res;
        end
        if (func == FUNC_UNSIGNED) begin
            restore_divide(a, b, q, r);
        end else begin
            a_neg = a[DW-1];
            b_neg = b[DW-1];
            ua = a_neg ? (~a + 1'b1) : a;
            ub = b_neg ? (~b + 1'b1) : b;
            restore_divide(ua, ub, q, r);
            if (a_neg != b_neg) q = ~q + 1'b1;
            if (a_neg) r = ~r + 1'b1;
        end
        res.quotient  = FIELD_W'(q);
        res.remainder = FIELD_W'(r);
        return res;
    endfunction

    // Operand mix: extremes, small values of either sign, short words and their complements, full random.
    function automatic logic [FIELD_W-1:0] pick_operand();
        logic [FIELD_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0: v = ZERO;
            1: v = 64'd1;
            2: v = ONES;
            3: v = SMIN;
            4: v = SMAX;
            5: v = FIELD_W'($urandom_range(1, 300));
            6: v = -FIELD_W'($urandom_range(1, 300));
            7: v = v >> $urandom_range(1, 63);
            8: v = ~(v >> $urandom_range(1, 63));
            default: ;
        endcase
        return v;
    endfunction

    // Offer one division and wait for the transfer; s_tready is sampled pre-edge.
    task automatic send_division(input logic func, input logic [FIELD_W-1:0] dividend,
                                 input logic [FIELD_W-1:0] divisor, input logic typed,
                                 input div_result_t typed_res);
        int gap;
        if (!quiet_tail && src_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {divisor, dividend};
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_divs.push_back(typed ? typed_res : predict_division(func, dividend, divisor));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_division(directed_rows[i].func, directed_rows[i].dividend,
                          directed_rows[i].divisor, directed_rows[i].typed,
                          directed_rows[i].res);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 64 == 0) src_gaps = ($urandom_range(0, 3) != 0);
            if (i == RAND_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
            send_division(1'($urandom_range(0, 1)), pick_operand(), pick_operand(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_divs.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (errors == 0) begin
            $display("int64_divider_signed_unsigned: match");
        end else begin
            $display("int64_divider_signed_unsigned: mismatch");
        end
        $finish;
    end

    // Result side back-pressure: stall bursts in some stretches, none in the tail.
    always @(posedge aclk) begin
        int stall_left;
        bit stall_mode;
        if (cycles % 256 == 0) stall_mode = ($urandom_range(0, 3) != 0);
        if (stall_left > 0) begin
            stall_left--;
        end else if (!quiet_tail && stall_mode && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 17);
        end
        m_tready <= (stall_left == 0);
    end

    // Result checker: every master transfer against the oldest pending division.
    always @(posedge aclk) begin
        div_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_divs.size() == 0) begin
                $error("result transfer with nothing pending: m_tdata %h m_tuser %b",
                       m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_divs.pop_front();
                if (m_tdata[FIELD_W-1:0] !== want.quotient) begin
                    $error("quotient: expected %h, actual %h", want.quotient,
                           m_tdata[FIELD_W-1:0]);
                    errors++;
                end
                if (m_tdata[2*FIELD_W-1:FIELD_W] !== want.remainder) begin
                    $error("remainder: expected %h, actual %h", want.remainder,
                           m_tdata[2*FIELD_W-1:FIELD_W]);
                    errors++;
                end
                if (m_tuser !== want.div_by_zero) begin
                    $error("div_by_zero: expected %b, actual %b", want.div_by_zero, m_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("int64_divider_signed_unsigned: mismatch");
        $finish;
    end

endmodule
